// ----- rtl/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler package
// Sizes, field widths, register indexes, color coefficients and the
// structs shared between the sampler modules.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // Store geometry.
  localparam int MAX_SRC_WIDTH  = 1024;
  localparam int MAX_SRC_HEIGHT = 1024;
  localparam int MAX_DST_SIZE   = 1024;

  localparam int CHROMA_ROWS  = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int PAIR_COLS    = (MAX_SRC_WIDTH + 1) / 2;
  localparam int LUMA_DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int CHROMA_DEPTH = CHROMA_ROWS * PAIR_COLS;
  localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
  localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH);
  localparam int SX_W         = $clog2(MAX_SRC_WIDTH);
  localparam int SY_W         = $clog2(MAX_SRC_HEIGHT);
  localparam int IDX_W        = (SX_W > SY_W) ? SX_W : SY_W;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int CFG_FIX_W  = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int LEVEL_W    = 16;

  // Mapping arithmetic.
  localparam int FRAC_BITS   = 16;
  localparam int MAG_W       = COORD_W + FRAC_BITS;
  localparam int DIFF_W      = CFG_FIX_W + 1;
  localparam int SCALE_LO_W  = 16;
  localparam int SCALE_HI_W  = CFG_FIX_W - SCALE_LO_W;
  localparam int PROD_LO_W   = MAG_W + SCALE_LO_W;
  localparam int PROD_HI_W   = MAG_W + SCALE_HI_W;
  localparam int PROD_W      = MAG_W + CFG_FIX_W;
  localparam int PROD_FRAC   = 2 * FRAC_BITS;
  localparam int HI_W        = PROD_W - PROD_FRAC;

  // Color conversion, Q2.14.
  localparam int COEF_Q      = 14;
  localparam int SUM_W       = 25;
  localparam int COEF_RV     = 22971;
  localparam int COEF_GU     = 5638;
  localparam int COEF_GV     = 11700;
  localparam int COEF_BU     = 29032;
  localparam int CHROMA_BIAS = 128;
  localparam int LEVEL_TOP   = 255 * 16384;
  localparam int LEVEL_SHIFT = 6;
  localparam int LEVEL_ROUND = 32;
  localparam logic [LEVEL_W-1:0] PAD_LEVEL = 16'd29184;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd65280;

  // Register reset values.
  localparam logic [SIZE_W-1:0]    RST_SRC_WIDTH  = 11'd1024;
  localparam logic [SIZE_W-1:0]    RST_SRC_HEIGHT = 11'd1024;
  localparam logic [SIZE_W-1:0]    RST_DST_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0]    RST_DST_HEIGHT = 11'd640;
  localparam logic [CFG_FIX_W-1:0] RST_INV_SCALE  = 27'd65536;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_LUMA   = 2'd0,
    OP_LOAD_CHROMA = 2'd1,
    OP_FETCH       = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_INV_SCALE  = 3'd4,
    REG_PAD_LEFT   = 3'd5,
    REG_PAD_TOP    = 3'd6
  } cfg_reg_e;

  // Sizes are already saturated to the store and destination limits.
  typedef struct packed {
    logic [SIZE_W-1:0]    pic_width;
    logic [SIZE_W-1:0]    pic_height;
    logic [SIZE_W-1:0]    dst_width;
    logic [SIZE_W-1:0]    dst_height;
    logic [CFG_FIX_W-1:0] inverse_scale;
    logic [CFG_FIX_W-1:0] pad_left;
    logic [CFG_FIX_W-1:0] pad_top;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } map_en_t;

  typedef struct packed {
    logic s5;
    logic s6;
  } color_en_t;

  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic                 in_range;
    logic [LUMA_AW-1:0]   luma_addr;
    logic [CHROMA_AW-1:0] chroma_addr;
    logic                 lane;
    logic [PIX_W-1:0]     data;
    logic [SX_W-1:0]      sx;
    logic [SY_W-1:0]      sy;
  } fs_req_t;

endpackage

// ----- rtl/lbs_cfg.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler configuration registers
// Holds the seven setup registers and presents saturated frame sizes.
// ----------------------------------------------------------------------------
module lbs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbs_pkg::CFG_FIX_W-1:0]    cfg_data_i,
  output lbs_pkg::cfg_t                    cfg_o
);

  logic [lbs_pkg::SIZE_W-1:0]    pic_width_q, pic_height_q;
  logic [lbs_pkg::SIZE_W-1:0]    dst_width_q, dst_height_q;
  logic [lbs_pkg::CFG_FIX_W-1:0] inv_scale_q, pad_left_q, pad_top_q;
  logic [lbs_pkg::SIZE_W-1:0]    size_data;

  function automatic logic [lbs_pkg::SIZE_W-1:0] sat_size(
    input logic [lbs_pkg::SIZE_W-1:0] v,
    input int unsigned                lim
  );
    if (32'(v) > lim) begin
      return lbs_pkg::SIZE_W'(lim);
    end
    return v;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign size_data   = cfg_data_i[lbs_pkg::SIZE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pic_width_q  <= lbs_pkg::RST_SRC_WIDTH;
      pic_height_q <= lbs_pkg::RST_SRC_HEIGHT;
      dst_width_q  <= lbs_pkg::RST_DST_WIDTH;
      dst_height_q <= lbs_pkg::RST_DST_HEIGHT;
      inv_scale_q  <= lbs_pkg::RST_INV_SCALE;
      pad_left_q   <= '0;
      pad_top_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (lbs_pkg::cfg_reg_e'(cfg_index_i))
        lbs_pkg::REG_SRC_WIDTH:  pic_width_q  <= size_data;
        lbs_pkg::REG_SRC_HEIGHT: pic_height_q <= size_data;
        lbs_pkg::REG_DST_WIDTH:  dst_width_q  <= size_data;
        lbs_pkg::REG_DST_HEIGHT: dst_height_q <= size_data;
        lbs_pkg::REG_INV_SCALE:  inv_scale_q  <= cfg_data_i;
        lbs_pkg::REG_PAD_LEFT:   pad_left_q   <= cfg_data_i;
        lbs_pkg::REG_PAD_TOP:    pad_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.pic_width     = sat_size(pic_width_q, lbs_pkg::MAX_SRC_WIDTH);
    cfg_o.pic_height    = sat_size(pic_height_q, lbs_pkg::MAX_SRC_HEIGHT);
    cfg_o.dst_width     = sat_size(dst_width_q, lbs_pkg::MAX_DST_SIZE);
    cfg_o.dst_height    = sat_size(dst_height_q, lbs_pkg::MAX_DST_SIZE);
    cfg_o.inverse_scale = inv_scale_q;
    cfg_o.pad_left      = pad_left_q;
    cfg_o.pad_top       = pad_top_q;
  end

endmodule

// ----- rtl/lbs_axis_map.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler axis mapper
// Three-stage map of one destination coordinate back to a source index:
// offset subtract, split multiply by the inverse scale, then sum, range
// check and round half up.
// ----------------------------------------------------------------------------
module lbs_axis_map (
  input  logic                            clk_i,
  input  lbs_pkg::map_en_t                en_i,
  input  logic [lbs_pkg::COORD_W-1:0]     dst_i,
  input  logic [lbs_pkg::CFG_FIX_W-1:0]   pad_i,
  input  logic [lbs_pkg::CFG_FIX_W-1:0]   scale_i,
  input  logic [lbs_pkg::SIZE_W-1:0]      size_i,
  output logic [lbs_pkg::IDX_W-1:0]       idx_o,
  output logic                            outside_o
);

  localparam int DW = lbs_pkg::DIFF_W;
  localparam int HW = lbs_pkg::HI_W;

  // Stage 1: signed offset.
  logic [lbs_pkg::MAG_W-1:0]     dst_fix;
  logic [DW-1:0]                 diff;
  logic                          neg_q;
  logic [lbs_pkg::MAG_W-1:0]     mag_q;
  // Stage 2: partial products.
  logic                          neg2_q;
  logic [lbs_pkg::PROD_LO_W-1:0] prod_lo_q;
  logic [lbs_pkg::PROD_HI_W-1:0] prod_hi_q;
  // Stage 3: sum and range check.
  logic [lbs_pkg::PROD_W-1:0]    prod;
  logic [HW-1:0]                 prod_int;
  logic [lbs_pkg::PROD_FRAC-1:0] prod_frac;
  logic [HW-1:0]                 top_idx;
  logic                          scale_zero;
  logic                          outside_d;
  logic [lbs_pkg::IDX_W-1:0]     idx_d;
  logic [lbs_pkg::IDX_W-1:0]     idx_q;
  logic                          outside_q;

  assign dst_fix = {dst_i, {lbs_pkg::FRAC_BITS{1'b0}}};
  assign diff    = DW'(dst_fix) - DW'(pad_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      neg_q <= diff[DW-1];
      mag_q <= diff[lbs_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      neg2_q    <= neg_q;
      prod_lo_q <= lbs_pkg::PROD_LO_W'(mag_q) *
                   lbs_pkg::PROD_LO_W'(scale_i[lbs_pkg::SCALE_LO_W-1:0]);
      prod_hi_q <= lbs_pkg::PROD_HI_W'(mag_q) *
                   lbs_pkg::PROD_HI_W'(scale_i[lbs_pkg::CFG_FIX_W-1:lbs_pkg::SCALE_LO_W]);
    end
  end

  always_comb begin
    prod       = {prod_hi_q, {lbs_pkg::SCALE_LO_W{1'b0}}} +
                 lbs_pkg::PROD_W'(prod_lo_q);
    prod_int   = prod[lbs_pkg::PROD_W-1:lbs_pkg::PROD_FRAC];
    prod_frac  = prod[lbs_pkg::PROD_FRAC-1:0];
    top_idx    = HW'(size_i - 1'b1);
    scale_zero = (scale_i == '0);
    // A negative offset with zero scale still lands on index zero.
    outside_d  = (size_i == '0) || (neg2_q && !scale_zero) ||
                 (!neg2_q && ((prod_int > top_idx) ||
                              ((prod_int == top_idx) && (prod_frac != '0))));
    if (neg2_q) begin
      idx_d = '0;
    end else begin
      idx_d = lbs_pkg::IDX_W'(prod_int + HW'(prod_frac[lbs_pkg::PROD_FRAC-1]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      idx_q     <= idx_d;
      outside_q <= outside_d;
    end
  end

  assign idx_o     = idx_q;
  assign outside_o = outside_q;

endmodule

// ----- rtl/lbs_frame_store.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler frame store
// Luma store plus chroma split into U and V halves. Loads and fetches use
// the same pipeline stage, so every access lands in arrival order.
// ----------------------------------------------------------------------------
module lbs_frame_store (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  lbs_pkg::fs_req_t              req_i,
  output logic [lbs_pkg::PIX_W-1:0]     y_o,
  output logic [lbs_pkg::PIX_W-1:0]     u_o,
  output logic [lbs_pkg::PIX_W-1:0]     v_o,
  output logic                          v_ok_o
);

  logic [lbs_pkg::PIX_W-1:0] luma_mem [lbs_pkg::LUMA_DEPTH];
  logic [lbs_pkg::PIX_W-1:0] u_mem    [lbs_pkg::CHROMA_DEPTH];
  logic [lbs_pkg::PIX_W-1:0] v_mem    [lbs_pkg::CHROMA_DEPTH];

  logic [lbs_pkg::LUMA_AW-1:0]   rd_luma_addr;
  logic [lbs_pkg::CHROMA_AW-1:0] rd_chroma_addr;
  logic                          rd_en, wr_luma, wr_u, wr_v, v_ok;
  logic [lbs_pkg::PIX_W-1:0]     y_q, u_q, v_q;
  logic                          v_ok_q;

  always_comb begin
    rd_luma_addr   = lbs_pkg::LUMA_AW'(32'(req_i.sy) * 32'(lbs_pkg::MAX_SRC_WIDTH) +
                                       32'(req_i.sx));
    rd_chroma_addr = lbs_pkg::CHROMA_AW'(32'(req_i.sy >> 1) * 32'(lbs_pkg::PAIR_COLS) +
                                         32'(req_i.sx >> 1));
    // The V sample of the last pair is missing when the store row width is odd.
    v_ok    = (32'(req_i.sx) | 32'd1) < 32'(lbs_pkg::MAX_SRC_WIDTH);
    rd_en   = en_i && req_i.valid && (req_i.op == lbs_pkg::OP_FETCH);
    wr_luma = en_i && req_i.valid && req_i.in_range && (req_i.op == lbs_pkg::OP_LOAD_LUMA);
    wr_u    = en_i && req_i.valid && req_i.in_range &&
              (req_i.op == lbs_pkg::OP_LOAD_CHROMA) && !req_i.lane;
    wr_v    = en_i && req_i.valid && req_i.in_range &&
              (req_i.op == lbs_pkg::OP_LOAD_CHROMA) && req_i.lane;
  end

  always_ff @(posedge clk_i) begin
    if (wr_luma) begin
      luma_mem[req_i.luma_addr] <= req_i.data;
    end
    if (rd_en) begin
      y_q <= luma_mem[rd_luma_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_u) begin
      u_mem[req_i.chroma_addr] <= req_i.data;
    end
    if (rd_en) begin
      u_q <= u_mem[rd_chroma_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_v) begin
      v_mem[req_i.chroma_addr] <= req_i.data;
    end
    if (rd_en) begin
      v_q    <= v_mem[rd_chroma_addr];
      v_ok_q <= v_ok;
    end
  end

  assign y_o    = y_q;
  assign u_o    = u_q;
  assign v_o    = v_q;
  assign v_ok_o = v_ok_q;

endmodule

// ----- rtl/lbs_color.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler color converter
// Full-range BT.601 YUV to RGB in Q2.14 over two stages: weighted sums,
// then clamp and round to Q8.8 levels, with the pad grey override.
// ----------------------------------------------------------------------------
module lbs_color (
  input  logic                          clk_i,
  input  lbs_pkg::color_en_t            en_i,
  input  logic [lbs_pkg::PIX_W-1:0]     y_i,
  input  logic [lbs_pkg::PIX_W-1:0]     u_i,
  input  logic [lbs_pkg::PIX_W-1:0]     v_i,
  input  logic                          v_ok_i,
  input  logic                          padded_i,
  output logic [lbs_pkg::LEVEL_W-1:0]   red_o,
  output logic [lbs_pkg::LEVEL_W-1:0]   green_o,
  output logic [lbs_pkg::LEVEL_W-1:0]   blue_o,
  output logic                          padded_o
);

  localparam int SW = lbs_pkg::SUM_W;

  logic signed [lbs_pkg::PIX_W:0] u_c, v_c;
  logic signed [SW-1:0]           y_q14;
  logic signed [SW-1:0]           r_d, g_d, b_d;
  logic signed [SW-1:0]           r_q, g_q, b_q;
  logic                           pad5_q;
  logic [lbs_pkg::LEVEL_W-1:0]    red_q, green_q, blue_q;
  logic                           pad6_q;

  function automatic logic [lbs_pkg::LEVEL_W-1:0] to_level(input logic signed [SW-1:0] v);
    logic [SW-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > SW'(lbs_pkg::LEVEL_TOP)) begin
      c = SW'(lbs_pkg::LEVEL_TOP);
    end else begin
      c = v;
    end
    return lbs_pkg::LEVEL_W'((c + SW'(lbs_pkg::LEVEL_ROUND)) >> lbs_pkg::LEVEL_SHIFT);
  endfunction

  always_comb begin
    u_c   = $signed({1'b0, u_i}) - (lbs_pkg::PIX_W + 1)'(lbs_pkg::CHROMA_BIAS);
    v_c   = v_ok_i ? $signed({1'b0, v_i}) - (lbs_pkg::PIX_W + 1)'(lbs_pkg::CHROMA_BIAS)
                   : '0;
    y_q14 = $signed(SW'({y_i, {lbs_pkg::COEF_Q{1'b0}}}));
    r_d   = y_q14 + SW'(lbs_pkg::COEF_RV * v_c);
    g_d   = y_q14 - SW'(lbs_pkg::COEF_GU * u_c) - SW'(lbs_pkg::COEF_GV * v_c);
    b_d   = y_q14 + SW'(lbs_pkg::COEF_BU * u_c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      r_q    <= r_d;
      g_q    <= g_d;
      b_q    <= b_d;
      pad5_q <= padded_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      red_q   <= pad5_q ? lbs_pkg::PAD_LEVEL : to_level(r_q);
      green_q <= pad5_q ? lbs_pkg::PAD_LEVEL : to_level(g_q);
      blue_q  <= pad5_q ? lbs_pkg::PAD_LEVEL : to_level(b_q);
      pad6_q  <= pad5_q;
    end
  end

  assign red_o    = red_q;
  assign green_o  = green_q;
  assign blue_o   = blue_q;
  assign padded_o = pad6_q;

endmodule

// ----- rtl/letterbox_nv12_to_rgb_sampler_top.sv -----
// Throughput: one beat per cycle unless the output stalls; a stage takes a new beat
// whenever it is empty or its content moves on, so bubbles close up during a stall.
// Six register stages: offset, split multiply, range check, store access,
// color sums, clamp and round into the output register.
// Reset clears the valid bits and loads the register defaults; stores are not cleared.
// ----------------------------------------------------------------------------
// Letterbox NV12 to RGB sampler
// Loads an NV12 frame into on-chip stores and streams letterboxed,
// nearest-neighbor RGB levels for requested destination pixels.
// ----------------------------------------------------------------------------
module letterbox_nv12_to_rgb_sampler_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbs_pkg::CFG_FIX_W-1:0]    cfg_data_i,
  // Input beats.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lbs_pkg::OP_W-1:0]         operation_i,
  input  logic [lbs_pkg::COORD_W-1:0]      row_i,
  input  logic [lbs_pkg::COORD_W-1:0]      column_i,
  input  logic [lbs_pkg::PIX_W-1:0]        byte_value_i,
  input  logic [lbs_pkg::COORD_W-1:0]      dst_x_i,
  input  logic [lbs_pkg::COORD_W-1:0]      dst_y_i,
  // Result beats.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lbs_pkg::LEVEL_W-1:0]      red_o,
  output logic [lbs_pkg::LEVEL_W-1:0]      green_o,
  output logic [lbs_pkg::LEVEL_W-1:0]      blue_o,
  output logic                             padded_o,
  output logic                             frame_end_o
);

  typedef struct packed {
    lbs_pkg::op_e                         op;
    logic                                 frame_end;
    logic                                 in_range;
    logic [lbs_pkg::LUMA_AW-1:0]          luma_addr;
    logic [lbs_pkg::CHROMA_AW-1:0]        chroma_addr;
    logic                                 lane;
    logic [lbs_pkg::PIX_W-1:0]            data;
  } item_t;

  lbs_pkg::cfg_t      cfg;
  lbs_pkg::map_en_t   map_en;
  lbs_pkg::color_en_t color_en;
  lbs_pkg::fs_req_t   fs_req;

  logic  en1, en2, en3, en4, en5, en6;
  logic  s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;
  logic  s1_valid_d;
  logic  op_known, luma_in, chroma_in;
  item_t item_d, s1_item_q, s2_item_q, s3_item_q;
  logic  s4_padded_q, s4_end_q, s5_end_q, s6_end_q;

  logic [lbs_pkg::IDX_W-1:0]   x_idx, y_idx;
  logic                        x_outside, y_outside;
  logic [lbs_pkg::PIX_W-1:0]   y_byte, u_byte, v_byte;
  logic                        v_ok;

  lbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Each stage moves when it is empty or the stage after it moves.
  always_comb begin
    en6 = !s6_valid_q || out_ready_i;
    en5 = !s5_valid_q || en6;
    en4 = !s4_valid_q || en5;
    en3 = !s3_valid_q || en4;
    en2 = !s2_valid_q || en3;
    en1 = !s1_valid_q || en2;
  end

  assign in_ready_o = en1;
  assign map_en     = '{s1: en1, s2: en2, s3: en3};
  assign color_en   = '{s5: en5, s6: en6};

  // Stage 1 decode: op check, frame end, load addresses.
  always_comb begin
    unique case (lbs_pkg::op_e'(operation_i)) inside
      lbs_pkg::OP_LOAD_LUMA, lbs_pkg::OP_LOAD_CHROMA, lbs_pkg::OP_FETCH: op_known = 1'b1;
      default: op_known = 1'b0;
    endcase
    luma_in   = (32'(row_i) < 32'(lbs_pkg::MAX_SRC_HEIGHT)) &&
                (32'(column_i) < 32'(lbs_pkg::MAX_SRC_WIDTH));
    chroma_in = (32'(row_i) < 32'(lbs_pkg::CHROMA_ROWS)) &&
                (32'(column_i) < 32'(lbs_pkg::MAX_SRC_WIDTH));

    item_d.op          = lbs_pkg::op_e'(operation_i);
    item_d.in_range    = (item_d.op == lbs_pkg::OP_LOAD_LUMA) ? luma_in : chroma_in;
    item_d.frame_end   = (cfg.dst_width != '0) && (cfg.dst_height != '0) &&
                         (lbs_pkg::SIZE_W'(dst_x_i) == cfg.dst_width - 1'b1) &&
                         (lbs_pkg::SIZE_W'(dst_y_i) == cfg.dst_height - 1'b1);
    item_d.luma_addr   = lbs_pkg::LUMA_AW'(32'(row_i) * 32'(lbs_pkg::MAX_SRC_WIDTH) +
                                           32'(column_i));
    item_d.chroma_addr = lbs_pkg::CHROMA_AW'(32'(row_i) * 32'(lbs_pkg::PAIR_COLS) +
                                             32'(column_i >> 1));
    item_d.lane        = column_i[0];
    item_d.data        = byte_value_i;

    s1_valid_d = in_valid_i && op_known;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= s1_valid_d;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
      // Loads end at the store stage and leave a bubble behind.
      if (en4) s4_valid_q <= s3_valid_q && (s3_item_q.op == lbs_pkg::OP_FETCH);
      if (en5) s5_valid_q <= s4_valid_q;
      if (en6) s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_item_q <= item_d;
    if (en2) s2_item_q <= s1_item_q;
    if (en3) s3_item_q <= s2_item_q;
    if (en4) begin
      s4_padded_q <= x_outside || y_outside;
      s4_end_q    <= s3_item_q.frame_end;
    end
    if (en5) s5_end_q <= s4_end_q;
    if (en6) s6_end_q <= s5_end_q;
  end

  lbs_axis_map u_map_x (
    .clk_i     (clk_i),
    .en_i      (map_en),
    .dst_i     (dst_x_i),
    .pad_i     (cfg.pad_left),
    .scale_i   (cfg.inverse_scale),
    .size_i    (cfg.pic_width),
    .idx_o     (x_idx),
    .outside_o (x_outside)
  );

  lbs_axis_map u_map_y (
    .clk_i     (clk_i),
    .en_i      (map_en),
    .dst_i     (dst_y_i),
    .pad_i     (cfg.pad_top),
    .scale_i   (cfg.inverse_scale),
    .size_i    (cfg.pic_height),
    .idx_o     (y_idx),
    .outside_o (y_outside)
  );

  always_comb begin
    fs_req.valid       = s3_valid_q;
    fs_req.op          = s3_item_q.op;
    fs_req.in_range    = s3_item_q.in_range;
    fs_req.luma_addr   = s3_item_q.luma_addr;
    fs_req.chroma_addr = s3_item_q.chroma_addr;
    fs_req.lane        = s3_item_q.lane;
    fs_req.data        = s3_item_q.data;
    fs_req.sx          = x_idx[lbs_pkg::SX_W-1:0];
    fs_req.sy          = y_idx[lbs_pkg::SY_W-1:0];
  end

  lbs_frame_store u_store (
    .clk_i  (clk_i),
    .en_i   (en4),
    .req_i  (fs_req),
    .y_o    (y_byte),
    .u_o    (u_byte),
    .v_o    (v_byte),
    .v_ok_o (v_ok)
  );

  lbs_color u_color (
    .clk_i    (clk_i),
    .en_i     (color_en),
    .y_i      (y_byte),
    .u_i      (u_byte),
    .v_i      (v_byte),
    .v_ok_i   (v_ok),
    .padded_i (s4_padded_q),
    .red_o    (red_o),
    .green_o  (green_o),
    .blue_o   (blue_o),
    .padded_o (padded_o)
  );

  assign out_valid_o = s6_valid_q;
  assign frame_end_o = s6_end_q;

  // An empty output stage must let the whole pipeline move.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output stage is empty");

  a_fetch_reaches_color : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && en4 && (s3_item_q.op == lbs_pkg::OP_FETCH)) |=> s4_valid_q)
    else $error("fetch beat lost at the store stage");

  a_pad_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && padded_o) |-> ((red_o == lbs_pkg::PAD_LEVEL) &&
                                   (green_o == lbs_pkg::PAD_LEVEL) &&
                                   (blue_o == lbs_pkg::PAD_LEVEL)))
    else $error("padded pixel without grey level");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((red_o <= lbs_pkg::LEVEL_MAX) && (green_o <= lbs_pkg::LEVEL_MAX) &&
                     (blue_o <= lbs_pkg::LEVEL_MAX)))
    else $error("color level above full scale");

endmodule

// ----- test/letterbox_nv12_to_rgb_sampler_checker.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler checker
// Watches the configuration, input and result channels of the sampler, keeps
// its own copy of the frame stores and registers, predicts every fetched pixel
// and compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module letterbox_nv12_to_rgb_sampler_checker
  import lbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_FIX_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   column_i,
  input  logic [PIX_W-1:0]     byte_value_i,
  input  logic [COORD_W-1:0]   dst_x_i,
  input  logic [COORD_W-1:0]   dst_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [LEVEL_W-1:0]   red_i,
  input  logic [LEVEL_W-1:0]   green_i,
  input  logic [LEVEL_W-1:0]   blue_i,
  input  logic                 padded_i,
  input  logic                 frame_end_i,
  output int                   pending_o,
  output int                   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Y_UNIT     = 16384;
  localparam longint K_RV       = 22971;
  localparam longint K_GU       = 5638;
  localparam longint K_GV       = 11700;
  localparam longint K_BU       = 29032;
  localparam longint SUM_CEIL   = 255 * 16384;
  localparam longint HALF_INDEX = 64'h0000_0000_8000_0000;
  localparam logic [LEVEL_W-1:0] GREY = 16'd29184;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               padded;
    logic               frame_end;
  } pixel_t;

  bit [PIX_W-1:0] luma_mem [int];
  bit [PIX_W-1:0] chroma_mem [int];
  pixel_t         awaited_px [$];

  logic [SIZE_W-1:0]    pic_width, pic_height, dst_width, dst_height;
  logic [CFG_FIX_W-1:0] inverse_scale, pad_left, pad_top;

  task automatic report_fault(input string msg);
    $display("[%0t] %s", $time, msg);
    errors_o = errors_o + 1;
  endtask

  // Maps one destination coordinate back to a source index, 0 when outside.
  function automatic bit map_axis(input logic [COORD_W-1:0] dst,
                                  input logic [CFG_FIX_W-1:0] pad,
                                  input logic [SIZE_W-1:0] size, input int limit,
                                  output int idx);
    longint span, diff, prod, ceiling;
    idx  = 0;
    span = (size > limit) ? limit : size;
    if (span == 0) return 1'b0;
    diff = (longint'(dst) <<< FRAC_BITS) - longint'(pad);
    prod = diff * longint'(inverse_scale);
    if (prod < 0) return 1'b0;
    ceiling = (span - 1) <<< 32;
    if (prod > ceiling) return 1'b0;
    idx = int'((prod + HALF_INDEX) >>> 32);
    if (idx > span - 1) idx = int'(span - 1);
    return 1'b1;
  endfunction

  function automatic logic [LEVEL_W-1:0] to_level(input longint sum);
    if (sum < 0) sum = 0;
    if (sum > SUM_CEIL) sum = SUM_CEIL;
    return LEVEL_W'((sum + 32) >>> 6);
  endfunction

  function automatic pixel_t predict_pixel(input logic [COORD_W-1:0] dx,
                                           input logic [COORD_W-1:0] dy);
    pixel_t px;
    int     sx, sy, ux, uy, dw, dh;
    bit     in_x, in_y;
    longint yq, u, v;
    dw = (dst_width > MAX_DST_SIZE) ? MAX_DST_SIZE : dst_width;
    dh = (dst_height > MAX_DST_SIZE) ? MAX_DST_SIZE : dst_height;
    px.frame_end = (dw != 0 && dh != 0 && dx == dw - 1 && dy == dh - 1);
    in_x = map_axis(dx, pad_left, pic_width, MAX_SRC_WIDTH, sx);
    in_y = map_axis(dy, pad_top, pic_height, MAX_SRC_HEIGHT, sy);
    if (in_x && in_y) begin
      ux = sx & ~1;
      uy = sy >> 1;
      yq = longint'(luma_mem[sy * MAX_SRC_WIDTH + sx]) * Y_UNIT;
      u  = longint'(chroma_mem[uy * MAX_SRC_WIDTH + ux]) - 128;
      // An odd-width store has no V byte for its last column pair.
      v  = (ux + 1 < MAX_SRC_WIDTH) ?
           longint'(chroma_mem[uy * MAX_SRC_WIDTH + ux + 1]) - 128 : 0;
      px.red    = to_level(yq + K_RV * v);
      px.green  = to_level(yq - K_GU * u - K_GV * v);
      px.blue   = to_level(yq + K_BU * u);
      px.padded = 1'b0;
    end else begin
      px.red    = GREY;
      px.green  = GREY;
      px.blue   = GREY;
      px.padded = 1'b1;
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t want;
    if (!rst_ni) begin
      pic_width     = 11'd1024;
      pic_height    = 11'd1024;
      dst_width     = 11'd640;
      dst_height    = 11'd640;
      inverse_scale = 27'd65536;
      pad_left      = '0;
      pad_top       = '0;
      awaited_px.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SRC_WIDTH:  pic_width     = cfg_data_i[SIZE_W-1:0];
          REG_SRC_HEIGHT: pic_height    = cfg_data_i[SIZE_W-1:0];
          REG_DST_WIDTH:  dst_width     = cfg_data_i[SIZE_W-1:0];
          REG_DST_HEIGHT: dst_height    = cfg_data_i[SIZE_W-1:0];
          REG_INV_SCALE:  inverse_scale = cfg_data_i;
          REG_PAD_LEFT:   pad_left      = cfg_data_i;
          REG_PAD_TOP:    pad_top       = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (operation_i)
          OP_LOAD_LUMA: begin
            luma_mem[int'(row_i) * MAX_SRC_WIDTH + int'(column_i)] = byte_value_i;
          end
          OP_LOAD_CHROMA: begin
            if (row_i < CHROMA_ROWS) begin
              chroma_mem[int'(row_i) * MAX_SRC_WIDTH + int'(column_i)] = byte_value_i;
            end
          end
          OP_FETCH: awaited_px.insert(awaited_px.size(), predict_pixel(dst_x_i, dst_y_i));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_px.size() == 0) begin
          report_fault("result beat with no fetch outstanding");
        end else begin
          want = awaited_px.pop_front();
          if (red_i !== want.red)
            report_fault($sformatf("red got %0d, expected %0d", red_i, want.red));
          if (green_i !== want.green)
            report_fault($sformatf("green got %0d, expected %0d", green_i, want.green));
          if (blue_i !== want.blue)
            report_fault($sformatf("blue got %0d, expected %0d", blue_i, want.blue));
          if (padded_i !== want.padded)
            report_fault($sformatf("padded got %b, expected %b", padded_i, want.padded));
          if (frame_end_i !== want.frame_end)
            report_fault($sformatf("frame_end got %b, expected %b",
                                   frame_end_i, want.frame_end));
        end
      end
    end
    pending_o = awaited_px.size();
  end

endmodule

// ----- test/letterbox_nv12_to_rgb_sampler_top_tb.sv -----
// ----------------------------------------------------------------------------
// Letterbox sampler testbench
// Loads small NV12 frames, programs letterbox settings between frames and
// streams fetch beats with random gaps and output stalls. The checker beside
// the sampler predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module letterbox_nv12_to_rgb_sampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbs_pkg::*;

  localparam int ITEM_GOAL    = 1800;
  localparam int GAP_MAX      = 17;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_REGS     = REG_PAD_TOP + 1;
  localparam int RUN_LIMIT_NS = 8_000_000;
  // At this inverse scale or below, every fetch lands on source index 0 or 1.
  localparam int SLOW_SCALE   = 64;
  localparam logic [CFG_FIX_W-1:0] FIX_MAX    = '1;
  localparam logic [CFG_FIX_W-1:0] ONE_Q16    = 27'd65536;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_FIX_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      operation_i = '0;
  logic [COORD_W-1:0]   row_i = '0;
  logic [COORD_W-1:0]   column_i = '0;
  logic [PIX_W-1:0]     byte_value_i = '0;
  logic [COORD_W-1:0]   dst_x_i = '0;
  logic [COORD_W-1:0]   dst_y_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [LEVEL_W-1:0]   red_o, green_o, blue_o;
  logic                 padded_o, frame_end_o;
  int                   pending, errors;

  logic [CFG_FIX_W-1:0] regs [NUM_REGS];
  int                   items_sent;
  bit                   eager;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  letterbox_nv12_to_rgb_sampler_top dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .operation_i, .row_i, .column_i, .byte_value_i,
    .dst_x_i, .dst_y_i,
    .out_valid_o, .out_ready_i, .red_o, .green_o, .blue_o, .padded_o, .frame_end_o
  );

  letterbox_nv12_to_rgb_sampler_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .row_i, .column_i,
    .byte_value_i, .dst_x_i, .dst_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .red_i(red_o), .green_i(green_o),
    .blue_i(blue_o), .padded_i(padded_o), .frame_end_i(frame_end_o),
    .pending_o(pending), .errors_o(errors)
  );

  // Every task starts and returns at a falling edge; valid stays high between
  // back-to-back beats.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col, input logic [PIX_W-1:0] val,
                           input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
    int gap;
    gap = eager ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i  <= op;
    row_i        <= row;
    column_i     <= col;
    byte_value_i <= val;
    dst_x_i      <= dx;
    dst_y_i      <= dy;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_load(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col, input logic [PIX_W-1:0] val);
    send_beat(op, row, col, val, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_fetch(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
    send_beat(OP_FETCH, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom), dx, dy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_FIX_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic program_regs();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), regs[i]);
    cfg_valid_i <= 1'b0;
  endtask

  // Loads stay in flight without a result, so let the pipeline settle past the
  // last result before touching the registers.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic fill_frame(input int fw, input int fh);
    for (int r = 0; r < fh; r++)
      for (int c = 0; c < fw; c++)
        send_load(OP_LOAD_LUMA, COORD_W'(r), COORD_W'(c), PIX_W'($urandom));
    // Chroma pairs cover an odd last column too.
    for (int r = 0; r < (fh + 1) / 2; r++)
      for (int c = 0; c < fw + (fw % 2); c++)
        send_load(OP_LOAD_CHROMA, COORD_W'(r), COORD_W'(c), PIX_W'($urandom));
  endtask

  function automatic logic [COORD_W-1:0] near_frame(input int span);
    if (span == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, (span + 1 > 1023) ? 1023 : span + 1));
  endfunction

  initial begin : drain_results
    int taken, stall;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      if (taken == 100 || taken == 400) stall = HOLD_CYCLES;
      else stall = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int fw, fh, dw, dh, nfetch, last_at, pick, phase;
    items_sent = 0;
    eager      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a 2x2 frame upscaled to 4x4, clamping at both ends, half-up
    // rounding, padding on both sides, ignored loads and the unused opcode.
    regs[REG_SRC_WIDTH]  = 27'd2;
    regs[REG_SRC_HEIGHT] = 27'd2;
    regs[REG_DST_WIDTH]  = 27'd4;
    regs[REG_DST_HEIGHT] = 27'd4;
    regs[REG_INV_SCALE]  = 27'd32768;
    regs[REG_PAD_LEFT]   = '0;
    regs[REG_PAD_TOP]    = '0;
    write_reg(REG_UNUSED, FIX_MAX);
    program_regs();
    send_load(OP_LOAD_LUMA, 10'd0, 10'd0, 8'd0);
    send_load(OP_LOAD_LUMA, 10'd0, 10'd1, 8'd255);
    send_load(OP_LOAD_LUMA, 10'd1, 10'd0, 8'd128);
    send_load(OP_LOAD_LUMA, 10'd1, 10'd1, 8'd255);
    send_load(OP_LOAD_CHROMA, 10'd0, 10'd0, 8'd0);
    send_load(OP_LOAD_CHROMA, 10'd0, 10'd1, 8'd255);
    send_load(OP_LOAD_CHROMA, 10'd1023, 10'd1023, 8'hAA);
    send_load(OP_LOAD_LUMA, 10'd1023, 10'd1023, 8'h55);
    send_load(OP_UNUSED, 10'd3, 10'd3, 8'd7);
    send_fetch(10'd0, 10'd0);
    send_fetch(10'd2, 10'd0);
    send_fetch(10'd1, 10'd1);
    send_fetch(10'd0, 10'd2);
    send_fetch(10'd3, 10'd3);
    send_fetch(10'd1023, 10'd0);
    send_fetch(10'd0, 10'd1023);
    wait_idle();
    regs[REG_PAD_LEFT] = 27'(2 * ONE_Q16);
    write_reg(REG_PAD_LEFT, regs[REG_PAD_LEFT]);
    cfg_valid_i <= 1'b0;
    send_fetch(10'd0, 10'd0);
    send_fetch(10'd2, 10'd1);
    send_fetch(10'd3, 10'd3);
    wait_idle();

    // Random frames: load a frame, then fetch letterboxed pixels with a little
    // noise mixed in. The stored region always covers every reachable index.
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      eager = ($urandom_range(0, 3) == 0);
      fw = 2;
      fh = 2;
      regs[REG_PAD_LEFT] = 27'($urandom_range(0, 8 * ONE_Q16));
      regs[REG_PAD_TOP]  = 27'($urandom_range(0, 8 * ONE_Q16));
      case (phase)
        0: begin
          regs[REG_SRC_WIDTH]  = 27'd1024;
          regs[REG_SRC_HEIGHT] = 27'd1024;
          regs[REG_DST_WIDTH]  = 27'd1024;
          regs[REG_DST_HEIGHT] = 27'd1024;
          regs[REG_INV_SCALE]  = 27'd1;
          regs[REG_PAD_LEFT]   = '0;
          regs[REG_PAD_TOP]    = '0;
        end
        1: begin
          // Sizes above the store saturate; a zero scale pins everything to 0.
          regs[REG_SRC_WIDTH]  = 27'd2047;
          regs[REG_SRC_HEIGHT] = 27'd2047;
          regs[REG_DST_WIDTH]  = 27'd2047;
          regs[REG_DST_HEIGHT] = 27'd2047;
          regs[REG_INV_SCALE]  = '0;
          regs[REG_PAD_LEFT]   = FIX_MAX;
          regs[REG_PAD_TOP]    = '0;
        end
        2: begin
          // Zero source width pads everything; zero destination width never
          // flags a frame end.
          regs[REG_SRC_WIDTH]  = '0;
          regs[REG_SRC_HEIGHT] = 27'd8;
          regs[REG_DST_WIDTH]  = '0;
          regs[REG_DST_HEIGHT] = 27'd5;
          regs[REG_INV_SCALE]  = FIX_MAX;
        end
        3: begin
          fw = 1;
          fh = 1;
          regs[REG_SRC_WIDTH]  = 27'd1;
          regs[REG_SRC_HEIGHT] = 27'd1;
          regs[REG_DST_WIDTH]  = 27'd1;
          regs[REG_DST_HEIGHT] = 27'd1;
          regs[REG_INV_SCALE]  = FIX_MAX;
          regs[REG_PAD_LEFT]   = '0;
          regs[REG_PAD_TOP]    = FIX_MAX;
        end
        4: begin
          fw = 8;
          fh = 8;
          regs[REG_SRC_WIDTH]  = 27'd8;
          regs[REG_SRC_HEIGHT] = 27'd8;
          regs[REG_DST_WIDTH]  = 27'd1024;
          regs[REG_DST_HEIGHT] = 27'd1;
          regs[REG_INV_SCALE]  = ONE_Q16;
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            // Large source but a tiny scale, so only the 2x2 corner is read.
            regs[REG_SRC_WIDTH]  = 27'($urandom_range(9, 2047));
            regs[REG_SRC_HEIGHT] = 27'($urandom_range(9, 2047));
            regs[REG_DST_WIDTH]  = 27'($urandom_range(1, 1024));
            regs[REG_DST_HEIGHT] = 27'($urandom_range(1, 1024));
            regs[REG_INV_SCALE]  = 27'($urandom_range(0, SLOW_SCALE));
            regs[REG_PAD_LEFT]   = 27'($urandom_range(0, 1023 * ONE_Q16));
            regs[REG_PAD_TOP]    = 27'($urandom_range(0, 1023 * ONE_Q16));
          end else begin
            fw = $urandom_range(1, 8);
            fh = $urandom_range(1, 8);
            regs[REG_SRC_WIDTH]  = 27'(fw);
            regs[REG_SRC_HEIGHT] = 27'(fh);
            regs[REG_DST_WIDTH]  = ($urandom_range(0, 9) == 0) ? 27'd1024 :
                                   27'($urandom_range(1, 16));
            regs[REG_DST_HEIGHT] = ($urandom_range(0, 9) == 0) ? 27'd1024 :
                                   27'($urandom_range(1, 16));
            pick = $urandom_range(0, 19);
            if (pick == 0) regs[REG_INV_SCALE] = '0;
            else if (pick < 3) regs[REG_INV_SCALE] = CFG_FIX_W'($urandom);
            else regs[REG_INV_SCALE] = 27'($urandom_range(1, 4 * ONE_Q16));
            if ($urandom_range(0, 9) == 0) regs[REG_PAD_LEFT] = CFG_FIX_W'($urandom);
            if ($urandom_range(0, 9) == 0) regs[REG_PAD_TOP] = CFG_FIX_W'($urandom);
          end
        end
      endcase
      program_regs();
      fill_frame(fw, fh);

      dw = (regs[REG_DST_WIDTH][SIZE_W-1:0] > MAX_DST_SIZE) ? MAX_DST_SIZE :
           int'(regs[REG_DST_WIDTH][SIZE_W-1:0]);
      dh = (regs[REG_DST_HEIGHT][SIZE_W-1:0] > MAX_DST_SIZE) ? MAX_DST_SIZE :
           int'(regs[REG_DST_HEIGHT][SIZE_W-1:0]);
      nfetch  = $urandom_range(20, 60);
      last_at = $urandom_range(0, nfetch - 1);
      for (int k = 0; k < nfetch; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_load(OP_W'($urandom_range(OP_LOAD_LUMA, OP_LOAD_CHROMA)),
                    COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
        end else if (pick < 11) begin
          send_load(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
        end
        if (k == last_at && dw != 0 && dh != 0) begin
          send_fetch(COORD_W'(dw - 1), COORD_W'(dh - 1));
        end else if (pick < 80) begin
          send_fetch(near_frame(dw), near_frame(dh));
        end else begin
          send_fetch(COORD_W'($urandom), COORD_W'($urandom));
        end
      end
      wait_idle();
      phase++;
    end

    if (errors == 0) begin
      $display("letterbox_nv12_to_rgb_sampler_top_tb OK");
    end else begin
      $display("letterbox_nv12_to_rgb_sampler_top_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("letterbox_nv12_to_rgb_sampler_top_tb NOT OK");
    $finish;
  end

endmodule
